// File: rtl/ulv_pkg.sv
// ulv_pkg: shared types and constants of the UTF-8 line validator.
// Holds the beat payload structs, the error codes and the decoder state.
// No dependencies.
package ulv_pkg;

    // Width of the line length field and of the max length register
    localparam int unsigned LEN_W = 16;

    // Reset value of the max length register
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 16'd1023;

    // Result codes, in order of priority after "ok"
    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_ENCODING  = 2'd1,
        ERR_TOO_SHORT = 2'd2,
        ERR_TOO_LONG  = 2'd3
    } err_code_t;

    // Range limit on the next continuation byte
    typedef enum logic [2:0] {
        CLS_PLAIN = 3'd0,   // 80-BF
        CLS_E0    = 3'd1,   // A0-BF
        CLS_ED    = 3'd2,   // 80-9F
        CLS_F0    = 3'd3,   // 90-BF
        CLS_F4    = 3'd4    // 80-8F
    } byte_class_t;

    // Byte constants of the decoder
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_SURR  = 8'hED;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF4;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] CONT_E0_LO  = 8'hA0;
    localparam logic [7:0] CONT_ED_HI  = 8'h9F;
    localparam logic [7:0] CONT_F0_LO  = 8'h90;
    localparam logic [7:0] CONT_F4_HI  = 8'h8F;

    // Decoder state carried from byte to byte
    typedef struct packed {
        logic [1:0]  bytes_pending;
        byte_class_t second_byte_class;
        logic        encoding_error;
    } dec_state_t;

    // Input beat payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_only;
        logic       last;
    } in_beat_t;

    // Result beat payload
    typedef struct packed {
        logic       line_ok;
        err_code_t  error_code;
        logic [LEN_W-1:0] line_length;
    } out_beat_t;

endpackage

// File: rtl/ulv_byte_check.sv
// ulv_byte_check: strict UTF-8 decoder step for one byte.
// Maps the current decoder state and a byte to the next decoder state.
// Depends on ulv_pkg.
module ulv_byte_check
    import ulv_pkg::*;
(
    input  dec_state_t dec_cur,
    input  logic [7:0] data_byte,
    output dec_state_t dec_next
);

    logic [7:0] cont_lo;
    logic [7:0] cont_hi;

    // Pick the allowed range of the next continuation byte
    always_comb begin
        cont_lo = CONT_LO;
        cont_hi = CONT_HI;
        unique case (dec_cur.second_byte_class)
            CLS_E0:  cont_lo = CONT_E0_LO;
            CLS_ED:  cont_hi = CONT_ED_HI;
            CLS_F0:  cont_lo = CONT_F0_LO;
            CLS_F4:  cont_hi = CONT_F4_HI;
            default: ;
        endcase
    end

    // Advance the decoder by one byte; once in error, hold
    always_comb begin
        dec_next = dec_cur;
        if (dec_cur.encoding_error) begin
            dec_next = dec_cur;
        end else if (dec_cur.bytes_pending != 2'd0) begin
            if (data_byte < cont_lo || data_byte > cont_hi) begin
                dec_next.encoding_error = 1'b1;
            end else begin
                dec_next.bytes_pending     = dec_cur.bytes_pending - 2'd1;
                dec_next.second_byte_class = CLS_PLAIN;
            end
        end else begin
            unique case (data_byte) inside
                CH_TAB, CH_LF, CH_CR, [CH_SPACE:CH_TILDE]: begin
                    dec_next = dec_cur;
                end
                [LEAD2_LO:LEAD2_HI]: begin
                    dec_next.bytes_pending     = 2'd1;
                    dec_next.second_byte_class = CLS_PLAIN;
                end
                [LEAD3_LO:LEAD3_HI]: begin
                    dec_next.bytes_pending     = 2'd2;
                    dec_next.second_byte_class =
                        (data_byte == LEAD3_LO)   ? CLS_E0 :
                        (data_byte == LEAD3_SURR) ? CLS_ED : CLS_PLAIN;
                end
                [LEAD4_LO:LEAD4_HI]: begin
                    dec_next.bytes_pending     = 2'd3;
                    dec_next.second_byte_class =
                        (data_byte == LEAD4_LO) ? CLS_F0 :
                        (data_byte == LEAD4_HI) ? CLS_F4 : CLS_PLAIN;
                end
                default: begin
                    dec_next.encoding_error = 1'b1;
                end
            endcase
        end
    end

endmodule

// File: rtl/utf8_line_validator.sv
// utf8_line_validator: top level of the strict UTF-8 line checker.
// Depends on ulv_pkg and ulv_byte_check.
//
// Usage:
//   Input channel s_*: one beat per byte of a text line (s_data.data_byte),
//   or a beat with end_only set that carries no byte. s_data.last marks the
//   final beat of the line. Result channel m_*: one beat per line, given for
//   the beat with last set: line_ok, error_code and the saturating length.
//   Configuration: cfg_wr_en with cfg_wr_data writes max_length; write it
//   only while no line is in flight.
// Pipeline and throughput:
//   A beat enters the input register, is decoded in the next cycle, and the
//   line result goes to the result register on m_* as the last beat leaves.
//   One beat per cycle is sustained while no last beat waits; the decode of
//   a beat is a single pass through the byte decoder and the length counter.
// Stall:
//   Beats that do not end a line keep flowing while a result waits on m_*.
//   A last beat waits in the input register until the result register is
//   free, and s_ready drops while it waits.
// Reset:
//   aresetn low clears both registers' valid flags and the line state, and
//   sets max_length to 1023.
module utf8_line_validator
    import ulv_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    // input channel
    input  logic       s_valid,
    output logic       s_ready,
    input  in_beat_t   s_data,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output out_beat_t  m_data
);

    localparam int unsigned CMP_W = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;
    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    logic [LEN_W-1:0]       max_length_reg;
    logic                   in_valid_reg;
    in_beat_t               in_reg;
    dec_state_t             dec_reg;
    dec_state_t             dec_next;
    dec_state_t             dec_step;
    logic [LENGTH_BITS-1:0] count_reg;
    logic [LENGTH_BITS-1:0] count_next;
    logic [LENGTH_BITS-1:0] count_step;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    out_beat_t              out_reg;
    out_beat_t              out_next;
    logic                   advance;
    logic                   proc;
    logic                   err_final;
    err_code_t              code;
    logic [CMP_W-1:0]       count_ext;
    logic [CMP_W-1:0]       max_ext;

    // Hold the max length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= MAX_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            max_length_reg <= cfg_wr_data;
        end
    end

    // A held beat moves on unless it ends a line and the result slot is busy
    assign advance = !in_reg.last || !m_valid_reg || m_ready;
    assign proc    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Capture input beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    // Decode the held byte
    ulv_byte_check u_byte_check (
        .dec_cur   (dec_reg),
        .data_byte (in_reg.data_byte),
        .dec_next  (dec_step)
    );

    // Count bytes, saturating
    always_comb begin
        count_step = count_reg;
        if (!in_reg.end_only && count_reg != COUNT_MAX) begin
            count_step = count_reg + 1'b1;
        end
    end

    // Grade the line at its last beat
    assign count_ext = CMP_W'(count_step);
    assign max_ext   = CMP_W'(max_length_reg);
    assign err_final = in_reg.end_only
                     ? (dec_reg.encoding_error || dec_reg.bytes_pending != 2'd0)
                     : (dec_step.encoding_error || dec_step.bytes_pending != 2'd0);

    always_comb begin
        if (err_final) begin
            code = ERR_ENCODING;
        end else if (count_ext < CMP_W'(2)) begin
            code = ERR_TOO_SHORT;
        end else if (count_ext > max_ext) begin
            code = ERR_TOO_LONG;
        end else begin
            code = ERR_OK;
        end
    end

    // Update line state; clear it after the last beat
    always_comb begin
        dec_next   = dec_reg;
        count_next = count_reg;
        if (proc) begin
            if (in_reg.last) begin
                dec_next   = '{bytes_pending: 2'd0, second_byte_class: CLS_PLAIN,
                               encoding_error: 1'b0};
                count_next = '0;
            end else begin
                dec_next   = in_reg.end_only ? dec_reg : dec_step;
                count_next = count_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg   <= '{bytes_pending: 2'd0, second_byte_class: CLS_PLAIN,
                           encoding_error: 1'b0};
            count_reg <= '0;
        end else begin
            dec_reg   <= dec_next;
            count_reg <= count_next;
        end
    end

    // Load the result register at a line end, drop it when taken
    always_comb begin
        out_next.line_ok     = (code == ERR_OK);
        out_next.error_code  = code;
        out_next.line_length = LEN_W'(count_ext);
        if (proc && in_reg.last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && in_reg.last) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    // line_ok agrees with the error code
    a_ok_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.line_ok == (m_data.error_code == ERR_OK)))
        else $error("line_ok disagrees with error_code");

    // A last beat never overwrites a result still waiting
    a_last_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_reg.last && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("last beat accepted over a waiting result");

    // Line state is cleared after a line ends
    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_reg.last) |=> (count_reg == '0 && dec_reg.bytes_pending == 2'd0
                                   && !dec_reg.encoding_error))
        else $error("line state not cleared after line end");

    // Too short is reported only for lines under two bytes
    a_short_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.error_code == ERR_TOO_SHORT) |-> (m_data.line_length < 2))
        else $error("too short reported for a long line");
`endif

endmodule
